// ===== rtl/core/mlcd_pkg.sv =====
package mlcd_pkg;

    localparam int COLUMNS   = 84;
    localparam int ROWS      = 6;
    localparam int RAM_DEPTH = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = 9;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;

    // Input tuser bits
    localparam int U_ACTION  = 0;
    localparam int U_IS_DATA = 1;

    // Display mode codes {D, E}
    localparam logic [1:0] MODE_BLANK   = 2'd0;
    localparam logic [1:0] MODE_ALL_ON  = 2'd1;
    localparam logic [1:0] MODE_NORMAL  = 2'd2;
    localparam logic [1:0] MODE_INVERSE = 2'd3;

    // Command opcodes and masks
    localparam logic [7:0] CMD_NOP       = 8'h00;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h20;
    localparam logic [7:0] CMD_FUNC_MASK = 8'hF8;
    localparam logic [7:0] CMD_DISP_CTL  = 8'h08;
    localparam logic [7:0] CMD_DISP_MASK = 8'hFA;
    localparam logic [7:0] CMD_SET_Y     = 8'h40;
    localparam logic [7:0] CMD_Y_MASK    = 8'hF8;
    localparam logic [7:0] CMD_TEMP      = 8'h04;
    localparam logic [7:0] CMD_TEMP_MASK = 8'hFC;
    localparam logic [7:0] CMD_BIAS      = 8'h10;
    localparam logic [7:0] CMD_BIAS_MASK = 8'hF8;

    // Output tdata bit positions
    localparam int O_WRITTEN = 0;
    localparam int O_ADDR    = 1;
    localparam int O_WDATA   = 10;
    localparam int O_RDATA   = 18;
    localparam int O_ERR     = 26;
    localparam int O_PD      = 27;
    localparam int O_MODE    = 28;
    localparam int O_VOP     = 30;
    localparam int O_BIAS    = 37;
    localparam int O_TC      = 40;
    localparam int O_VERT    = 42;
    localparam int O_EXT     = 43;

    typedef struct packed {
        logic              written;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              err;
        logic              pd;
        logic [1:0]        mode;
        logic [6:0]        vop;
        logic [2:0]        bias;
        logic [1:0]        tc;
        logic              vert;
        logic              ext;
    } mlcd_res_t;

endpackage

// ===== rtl/core/mono_lcd_controller_command_ram_top.sv =====
// Receive side of an 84x48 monochrome LCD controller. Each transaction is a
// host byte (tuser[1] = D/C) or a scan-out fetch (tuser[0] = 1). Data bytes
// go to the 504-byte display RAM at the X/Y pointer, which then advances;
// command bytes update the control registers. One transaction per clock is
// accepted while the output side is not stalled. A result passes two register
// stages before it is presented on m_tvalid: the first register stage holds the
// synchronous display RAM read, the second is the output register. Every
// transaction returns exactly one result carrying the status after it.
module mono_lcd_controller_command_ram_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] byte_value, [16:8] fetch_addr, [23:17] zero
    input  logic [mlcd_pkg::IN_DATA_W-1:0]   s_tdata,
    // [0] action, [1] is_data
    input  logic [mlcd_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] ram_written, [9:1] ram_addr, [17:10] ram_data, [25:18] read_data,
    // [26] command_error, [27] powered_down, [29:28] display_mode,
    // [36:30] contrast_voltage, [39:37] bias_level, [41:40] temp_coeff,
    // [42] addressing_vertical, [43] extended_set, [47:44] zero
    output logic [mlcd_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import mlcd_pkg::*;

    localparam logic [7:0]        COLUMNS_B = 8'(COLUMNS);
    localparam logic [3:0]        ROWS_B    = 4'(ROWS);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

    logic [7:0] display_ram [RAM_DEPTH];
    logic [7:0] ram_q_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             pd_reg, pd_next;
    logic             vert_reg, vert_next;
    logic             ext_reg, ext_next;
    logic [1:0]       mode_reg, mode_next;
    logic [6:0]       vop_reg, vop_next;
    logic [2:0]       bias_reg, bias_next;
    logic [1:0]       tc_reg, tc_next;

    logic             s1_valid_reg;
    mlcd_res_t        s1_res_reg, s1_res_next;
    logic             s1_fetch_reg;
    logic [1:0]       s1_mode_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic              accept;
    logic              s1_move;
    logic              action;
    logic              is_data;
    logic [7:0]        byte_value;
    logic [ADDR_W-1:0] fetch_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              fetch_ok;
    logic              cmd_err;
    logic [7:0]        rdata;

    assign action     = s_tuser[U_ACTION];
    assign is_data    = s_tuser[U_IS_DATA];
    assign byte_value = s_tdata[7:0];
    assign fetch_addr = s_tdata[8 +: ADDR_W];

    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    assign wr_addr  = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign fetch_ok = action && !pd_reg && (fetch_addr < ADDR_W'(RAM_DEPTH));

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pd_next   = pd_reg;
        vert_next = vert_reg;
        ext_next  = ext_reg;
        mode_next = mode_reg;
        vop_next  = vop_reg;
        bias_next = bias_reg;
        tc_next   = tc_reg;
        cmd_err   = 1'b0;
        if (!action && is_data)
        begin
            if (vert_reg)
            begin
                if (row_reg == ROW_LAST)
                begin
                    row_next = '0;
                    col_next = (col_reg == COL_LAST) ? '0 : col_reg + 1'b1;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                if (col_reg == COL_LAST)
                begin
                    col_next = '0;
                    row_next = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
        else if (!action)
        begin
            priority if (byte_value == CMD_NOP)
            begin
                cmd_err = 1'b0;
            end
            else if ((byte_value & CMD_FUNC_MASK) == CMD_FUNC_SET)
            begin
                pd_next   = byte_value[2];
                vert_next = byte_value[1];
                ext_next  = byte_value[0];
            end
            else if (ext_reg)
            begin
                priority if (byte_value[7])
                    vop_next = byte_value[6:0];
                else if ((byte_value & CMD_TEMP_MASK) == CMD_TEMP)
                    tc_next = byte_value[1:0];
                else if ((byte_value & CMD_BIAS_MASK) == CMD_BIAS)
                    bias_next = byte_value[2:0];
                else
                    cmd_err = 1'b1;
            end
            else if (byte_value[7])
            begin
                if ({1'b0, byte_value[6:0]} >= COLUMNS_B)
                    cmd_err = 1'b1;
                else
                    col_next = COL_W'(byte_value[6:0]);
            end
            else if ((byte_value & CMD_Y_MASK) == CMD_SET_Y)
            begin
                if ({1'b0, byte_value[2:0]} >= ROWS_B)
                    cmd_err = 1'b1;
                else
                    row_next = ROW_W'(byte_value[2:0]);
            end
            else if ((byte_value & CMD_DISP_MASK) == CMD_DISP_CTL)
            begin
                mode_next = {byte_value[2], byte_value[0]};
            end
            else
            begin
                cmd_err = 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_res_next.written = !action && is_data;
        s1_res_next.waddr   = (!action && is_data) ? wr_addr : '0;
        s1_res_next.wdata   = (!action && is_data) ? byte_value : '0;
        s1_res_next.err     = cmd_err;
        s1_res_next.pd      = pd_next;
        s1_res_next.mode    = mode_next;
        s1_res_next.vop     = vop_next;
        s1_res_next.bias    = bias_next;
        s1_res_next.tc      = tc_next;
        s1_res_next.vert    = vert_next;
        s1_res_next.ext     = ext_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && !action && is_data)
        begin
            display_ram[wr_addr] <= byte_value;
        end
        if (accept && fetch_ok)
        begin
            ram_q_reg <= display_ram[fetch_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pd_reg   <= 1'b1;
            vert_reg <= 1'b0;
            ext_reg  <= 1'b0;
            mode_reg <= MODE_BLANK;
            vop_reg  <= '0;
            bias_reg <= '0;
            tc_reg   <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pd_reg   <= pd_next;
            vert_reg <= vert_next;
            ext_reg  <= ext_next;
            mode_reg <= mode_next;
            vop_reg  <= vop_next;
            bias_reg <= bias_next;
            tc_reg   <= tc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg   <= s1_res_next;
            s1_fetch_reg <= fetch_ok;
            s1_mode_reg  <= mode_reg;
        end
    end

    always_comb
    begin
        rdata = '0;
        if (s1_fetch_reg)
        begin
            unique case (s1_mode_reg)
                MODE_BLANK:   rdata = 8'h00;
                MODE_ALL_ON:  rdata = 8'hFF;
                MODE_NORMAL:  rdata = ram_q_reg;
                MODE_INVERSE: rdata = ~ram_q_reg;
                default:      rdata = 8'h00;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= {4'b0000,
                             s1_res_reg.ext, s1_res_reg.vert, s1_res_reg.tc,
                             s1_res_reg.bias, s1_res_reg.vop, s1_res_reg.mode,
                             s1_res_reg.pd, s1_res_reg.err, rdata,
                             s1_res_reg.wdata, s1_res_reg.waddr,
                             s1_res_reg.written};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/mlcd_checker.sv =====
module mlcd_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mlcd_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import mlcd_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[O_WRITTEN] |->
            m_tdata[O_RDATA +: 8] == 8'h00 && !m_tdata[O_ERR])
        else $error("data write transaction carries read data or error");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[O_ADDR +: ADDR_W] < ADDR_W'(RAM_DEPTH))
        else $error("write address beyond display RAM");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[O_RDATA +: 8] != 8'h00 |-> !m_tdata[O_PD])
        else $error("nonzero fetch while powered down");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[O_WRITTEN] |->
            m_tdata[O_ADDR +: ADDR_W] == '0 && m_tdata[O_WDATA +: 8] == 8'h00)
        else $error("address or data set without a RAM write");

endmodule

bind mono_lcd_controller_command_ram_top mlcd_checker u_mlcd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_mono_lcd_controller_command_ram_top.sv =====
`timescale 1ns / 1ps

module tb_mono_lcd_controller_command_ram_top;

    import mlcd_pkg::*;

    localparam logic [7:0] CMD_SET_X      = 8'h80;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASE_ITEMS    = 112;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
        logic       is_data;
        logic [8:0] fetch_addr;
    } lcd_item_t;

    typedef struct packed {
        logic              ram_written;
        logic [ADDR_W-1:0] ram_addr;
        logic [7:0]        ram_data;
        logic [7:0]        read_data;
        logic              command_error;
        logic              powered_down;
        logic [1:0]        display_mode;
        logic [6:0]        contrast_voltage;
        logic [2:0]        bias_level;
        logic [1:0]        temp_coeff;
        logic              addressing_vertical;
        logic              extended_set;
    } lcd_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // controller shadow state
    logic [7:0] shadow_ram [RAM_DEPTH];
    bit         was_written [RAM_DEPTH];
    int         written_addrs [$];
    logic [6:0] col_ptr = '0;
    logic [2:0] row_ptr = '0;
    logic       pd_bit = 1'b1;
    logic       vert_bit = 1'b0;
    logic       ext_bit = 1'b0;
    logic [1:0] mode_bits = MODE_BLANK;
    logic [6:0] vop_bits = '0;
    logic [2:0] bias_bits = '0;
    logic [1:0] tc_bits = '0;

    lcd_item_t   byte_q [$];
    lcd_result_t planned_q [$];
    lcd_result_t pending_q [$];

    int errors = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    mono_lcd_controller_command_ram_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic lcd_result_t lcd_apply(input lcd_item_t it);
        lcd_result_t       r;
        logic [7:0]        c;
        logic [7:0]        v;
        logic [ADDR_W-1:0] a;
        r = '0;
        c = it.byte_value;
        if (it.action)
        begin
            if (!pd_bit && it.fetch_addr < RAM_DEPTH)
            begin
                v = shadow_ram[it.fetch_addr];
                case (mode_bits)
                    MODE_BLANK:  r.read_data = 8'h00;
                    MODE_ALL_ON: r.read_data = 8'hFF;
                    MODE_NORMAL: r.read_data = v;
                    default:     r.read_data = ~v;
                endcase
            end
        end
        else if (it.is_data)
        begin
            a = ADDR_W'(row_ptr * COLUMNS + col_ptr);
            shadow_ram[a] = c;
            if (!was_written[a])
            begin
                was_written[a] = 1'b1;
                written_addrs.push_back(int'(a));
            end
            r.ram_written = 1'b1;
            r.ram_addr    = a;
            r.ram_data    = c;
            if (vert_bit)
            begin
                row_ptr = row_ptr + 1'b1;
                if (row_ptr >= ROWS)
                begin
                    row_ptr = '0;
                    col_ptr = col_ptr + 1'b1;
                    if (col_ptr >= COLUMNS)
                        col_ptr = '0;
                end
            end
            else
            begin
                col_ptr = col_ptr + 1'b1;
                if (col_ptr >= COLUMNS)
                begin
                    col_ptr = '0;
                    row_ptr = row_ptr + 1'b1;
                    if (row_ptr >= ROWS)
                        row_ptr = '0;
                end
            end
        end
        else if (c == CMD_NOP)
        begin
            r.command_error = 1'b0;
        end
        else if ((c & CMD_FUNC_MASK) == CMD_FUNC_SET)
        begin
            pd_bit   = c[2];
            vert_bit = c[1];
            ext_bit  = c[0];
        end
        else if (ext_bit)
        begin
            if ((c & CMD_SET_X) != 0)
                vop_bits = c[6:0];
            else if ((c & CMD_TEMP_MASK) == CMD_TEMP)
                tc_bits = c[1:0];
            else if ((c & CMD_BIAS_MASK) == CMD_BIAS)
                bias_bits = c[2:0];
            else
                r.command_error = 1'b1;
        end
        else if ((c & CMD_SET_X) != 0)
        begin
            if (c[6:0] >= COLUMNS)
                r.command_error = 1'b1;
            else
                col_ptr = c[6:0];
        end
        else if ((c & CMD_Y_MASK) == CMD_SET_Y)
        begin
            if (c[2:0] >= ROWS)
                r.command_error = 1'b1;
            else
                row_ptr = c[2:0];
        end
        else if ((c & CMD_DISP_MASK) == CMD_DISP_CTL)
        begin
            mode_bits = {c[2], c[0]};
        end
        else
        begin
            r.command_error = 1'b1;
        end
        r.powered_down        = pd_bit;
        r.display_mode        = mode_bits;
        r.contrast_voltage    = vop_bits;
        r.bias_level          = bias_bits;
        r.temp_coeff          = tc_bits;
        r.addressing_vertical = vert_bit;
        r.extended_set        = ext_bit;
        return r;
    endfunction

    function automatic lcd_item_t cmd_byte(input logic [7:0] b);
        lcd_item_t it;
        it.action     = 1'b0;
        it.byte_value = b;
        it.is_data    = 1'b0;
        it.fetch_addr = 9'($urandom_range(511));
        return it;
    endfunction

    function automatic lcd_item_t pixel_byte(input logic [7:0] b);
        lcd_item_t it;
        it = cmd_byte(b);
        it.is_data = 1'b1;
        return it;
    endfunction

    function automatic lcd_item_t scan_fetch(input logic [8:0] addr);
        lcd_item_t it;
        it.action     = 1'b1;
        it.byte_value = 8'($urandom_range(255));
        it.is_data    = 1'($urandom_range(1));
        it.fetch_addr = addr;
        return it;
    endfunction

    // only written entries or out-of-range addresses are ever fetched
    function automatic lcd_item_t random_byte();
        int         sel;
        logic [7:0] c;
        sel = $urandom_range(99);
        if (sel < 35)
            return pixel_byte(8'($urandom_range(255)));
        if (sel >= 65)
        begin
            if (written_addrs.size() == 0 || $urandom_range(7) == 0)
                return scan_fetch(9'($urandom_range(511, RAM_DEPTH)));
            return scan_fetch(9'(written_addrs[$urandom_range(written_addrs.size() - 1)]));
        end
        case ($urandom_range(8))
            0:       c = CMD_FUNC_SET | (($urandom_range(99) < 15) ? 8'h04 : 8'h00)
                         | 8'($urandom_range(3));
            1:       c = CMD_DISP_CTL | ($urandom_range(1) ? 8'h04 : 8'h00)
                         | 8'($urandom_range(1));
            2:       c = CMD_SET_X | (($urandom_range(5) == 0) ? 8'($urandom_range(127, COLUMNS))
                                                               : 8'($urandom_range(COLUMNS - 1)));
            3:       c = CMD_SET_Y | 8'($urandom_range(7));
            4:       c = CMD_TEMP | 8'($urandom_range(3));
            5:       c = CMD_BIAS | 8'($urandom_range(7));
            6:       c = CMD_NOP;
            default: c = 8'($urandom_range(255));
        endcase
        return cmd_byte(c);
    endfunction

    task automatic queue_byte(input lcd_item_t it);
        planned_q.push_back(lcd_apply(it));
        byte_q.push_back(it);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
            queue_byte(random_byte());
        while (byte_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        lcd_item_t            it;
        logic [IN_USER_W-1:0] user_bits;
        if (rst_n)
        begin
            if (!s_tvalid || s_tready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    it = byte_q.pop_front();
                    user_bits = '0;
                    user_bits[U_ACTION]  = it.action;
                    user_bits[U_IS_DATA] = it.is_data;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W - 17){1'b0}}, it.fetch_addr, it.byte_value};
                    s_tuser  <= user_bits;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        lcd_result_t want;
        lcd_result_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transaction with none pending, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = pending_q.pop_front();
                    got.ram_written         = m_tdata[O_WRITTEN];
                    got.ram_addr            = m_tdata[O_ADDR +: ADDR_W];
                    got.ram_data            = m_tdata[O_WDATA +: 8];
                    got.read_data           = m_tdata[O_RDATA +: 8];
                    got.command_error       = m_tdata[O_ERR];
                    got.powered_down        = m_tdata[O_PD];
                    got.display_mode        = m_tdata[O_MODE +: 2];
                    got.contrast_voltage    = m_tdata[O_VOP +: 7];
                    got.bias_level          = m_tdata[O_BIAS +: 3];
                    got.temp_coeff          = m_tdata[O_TC +: 2];
                    got.addressing_vertical = m_tdata[O_VERT];
                    got.extended_set        = m_tdata[O_EXT];
                    check_field("ram_written", 9'(want.ram_written), 9'(got.ram_written));
                    check_field("ram_addr", want.ram_addr, got.ram_addr);
                    check_field("ram_data", 9'(want.ram_data), 9'(got.ram_data));
                    check_field("read_data", 9'(want.read_data), 9'(got.read_data));
                    check_field("command_error", 9'(want.command_error),
                                9'(got.command_error));
                    check_field("powered_down", 9'(want.powered_down),
                                9'(got.powered_down));
                    check_field("display_mode", 9'(want.display_mode),
                                9'(got.display_mode));
                    check_field("contrast_voltage", 9'(want.contrast_voltage),
                                9'(got.contrast_voltage));
                    check_field("bias_level", 9'(want.bias_level), 9'(got.bias_level));
                    check_field("temp_coeff", 9'(want.temp_coeff), 9'(got.temp_coeff));
                    check_field("addressing_vertical", 9'(want.addressing_vertical),
                                9'(got.addressing_vertical));
                    check_field("extended_set", 9'(want.extended_set),
                                9'(got.extended_set));
                end
            end
            if (s_tvalid && s_tready)
                pending_q.push_back(planned_q.pop_front());
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        // powered down at reset: fetch gives zero, writes still land
        queue_byte(scan_fetch(9'd511));
        queue_byte(cmd_byte(CMD_NOP));
        queue_byte(pixel_byte(8'hFF));
        queue_byte(cmd_byte(8'h21));
        queue_byte(cmd_byte(8'h07));
        queue_byte(cmd_byte(8'h17));
        queue_byte(cmd_byte(8'hFF));
        queue_byte(cmd_byte(8'h80));
        queue_byte(cmd_byte(8'h40));
        // vertical addressing, wrap from the last address to the origin
        queue_byte(cmd_byte(8'h22));
        queue_byte(cmd_byte(8'h0C));
        queue_byte(cmd_byte(8'hD3));
        queue_byte(cmd_byte(8'h45));
        queue_byte(pixel_byte(8'hA5));
        queue_byte(pixel_byte(8'h00));
        queue_byte(scan_fetch(9'd503));
        queue_byte(cmd_byte(8'hD4));
        queue_byte(cmd_byte(8'h46));
        queue_byte(cmd_byte(8'h0D));
        queue_byte(scan_fetch(9'd503));
        queue_byte(cmd_byte(8'h09));
        queue_byte(scan_fetch(9'd0));
        queue_byte(cmd_byte(8'h0A));
        queue_byte(scan_fetch(9'd504));
        queue_byte(cmd_byte(8'h24));
        queue_byte(scan_fetch(9'd0));
        // horizontal wrap
        queue_byte(cmd_byte(8'h20));
        queue_byte(cmd_byte(8'hD3));
        queue_byte(cmd_byte(8'h45));
        queue_byte(pixel_byte(8'h3C));
        queue_byte(pixel_byte(8'hC3));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0)
            @(negedge clk);
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(80, 0, PHASE_ITEMS);
        run_phase(0, 80, PHASE_ITEMS);
        run_phase(22, 22, PHASE_ITEMS);

        while (byte_q.size() != 0 || pending_q.size() != 0 || s_tvalid)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
